@@ hw/rtl/tftp_data_sender_unit_defines.svh @@
// assertion macros for the tftp data sender rtl
`ifndef TFTP_DATA_SENDER_UNIT_DEFINES_SVH
`define TFTP_DATA_SENDER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define TDS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tds invariant violated");

// consequence that must hold in the cycle after the trigger
`define TDS_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("tds sequence violated");

`else

`define TDS_ASSERT_ALWAYS(lbl, cond)
`define TDS_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

@@ hw/rtl/tds_pkg.sv @@
// types and constants of the tftp data sender
`timescale 1ns / 1ps

package tds_pkg;

    // request actions
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_LOADED  = 2'd1;
    localparam logic [1:0] ACT_REPLY   = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    // transfer phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOAD = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FETCH = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // error codes
    localparam logic ERR_RETRIES   = 1'b0;
    localparam logic ERR_NOT_FOUND = 1'b1;

    // protocol constants
    localparam logic [7:0]  OP_ACK        = 8'd4;
    localparam logic [9:0]  MIN_REPLY_LEN = 10'd4;
    localparam logic [9:0]  BLOCK_SIZE    = 10'd512;
    localparam logic [15:0] LAST_BLOCK    = 16'hFFFF;
    localparam logic [15:0] FIRST_BLOCK   = 16'd1;
    localparam logic [3:0]  RETRY_RESET   = 4'd5;

    // register map
    localparam logic REG_RETRY_LIMIT = 1'b0;

    typedef struct packed {
        logic [1:0]  action;
        logic        file_found;
        logic [9:0]  block_bytes;
        logic [7:0]  reply_opcode;
        logic [15:0] reply_block;
        logic [9:0]  reply_length;
    } tds_item_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] current_block;
        logic [3:0]  sends_done;
        logic [9:0]  held_length;
    } tds_state_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] block_number;
        logic [9:0]  payload_bytes;
        logic        error_code;
    } tds_result_t;

endpackage

@@ hw/rtl/tds_step.sv @@
// per-request decision logic: next transfer state and optional result
`timescale 1ns / 1ps

module tds_step
(
    input  tds_pkg::tds_item_t   item,
    input  tds_pkg::tds_state_t  state,
    input  logic [3:0]           retry_limit,
    output tds_pkg::tds_state_t  state_next,
    output tds_pkg::tds_result_t result
);
    import tds_pkg::*;

    logic        ack_ok;
    logic        retry_exhausted;
    logic [9:0]  sat_bytes;
    logic [15:0] block_inc;

    // reply checks and helpers
    assign ack_ok = (item.reply_length >= MIN_REPLY_LEN) && (item.reply_opcode == OP_ACK)
                    && (item.reply_block == state.current_block);
    assign retry_exhausted = (state.sends_done >= retry_limit);
    assign sat_bytes = (item.block_bytes > BLOCK_SIZE) ? BLOCK_SIZE : item.block_bytes;
    assign block_inc = (state.current_block == LAST_BLOCK) ? FIRST_BLOCK
                                                           : state.current_block + 16'd1;

    // transfer decision
    always_comb
    begin
        state_next           = state;
        result.valid         = 1'b0;
        result.kind          = KIND_DATA;
        result.block_number  = 16'd0;
        result.payload_bytes = 10'd0;
        result.error_code    = ERR_RETRIES;

        case (item.action)
            ACT_START:
            begin
                if (state.phase == PH_IDLE)
                begin
                    result.valid = 1'b1;
                    if (!item.file_found)
                    begin
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_NOT_FOUND;
                    end
                    else
                    begin
                        state_next.current_block = FIRST_BLOCK;
                        state_next.sends_done    = 4'd0;
                        state_next.held_length   = 10'd0;
                        state_next.phase         = PH_LOAD;
                        result.kind              = KIND_FETCH;
                        result.block_number      = FIRST_BLOCK;
                    end
                end
            end
            ACT_LOADED:
            begin
                if (state.phase == PH_LOAD)
                begin
                    state_next.held_length = sat_bytes;
                    state_next.sends_done  = 4'd1;
                    state_next.phase       = PH_WAIT;
                    result.valid           = 1'b1;
                    result.kind            = KIND_DATA;
                    result.block_number    = state.current_block;
                    result.payload_bytes   = sat_bytes;
                end
            end
            ACT_REPLY, ACT_TIMEOUT:
            begin
                if (state.phase == PH_WAIT)
                begin
                    result.valid = 1'b1;
                    if ((item.action == ACT_REPLY) && ack_ok)
                    begin
                        if (state.held_length < BLOCK_SIZE)
                        begin
                            // short block acknowledged: transfer done
                            state_next.phase    = PH_IDLE;
                            result.kind         = KIND_DONE;
                            result.block_number = state.current_block;
                        end
                        else
                        begin
                            state_next.current_block = block_inc;
                            state_next.sends_done    = 4'd0;
                            state_next.phase         = PH_LOAD;
                            result.kind              = KIND_FETCH;
                            result.block_number      = block_inc;
                        end
                    end
                    else if (retry_exhausted)
                    begin
                        state_next.phase  = PH_IDLE;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_RETRIES;
                    end
                    else
                    begin
                        // resend the held block
                        state_next.sends_done = state.sends_done + 4'd1;
                        result.kind           = KIND_DATA;
                        result.block_number   = state.current_block;
                        result.payload_bytes  = state.held_length;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

@@ hw/rtl/tftp_data_sender_unit.sv @@
// tftp data sender top level: request register, decision step, result register
// a request taken into the request register has its result loaded into the result register when that is free or drains
// throughput: one request per cycle; stall from the result side holds the request register
// a request that causes no result only updates the transfer state
// reset (rst_n low, asynchronous): phase idle, block 1, no sends, retry limit 5
`timescale 1ns / 1ps
`include "tftp_data_sender_unit_defines.svh"

module tftp_data_sender_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic        file_found,
    input  logic [9:0]  block_bytes,
    input  logic [7:0]  reply_opcode,
    input  logic [15:0] reply_block,
    input  logic [9:0]  reply_length,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [15:0] block_number,
    output logic [9:0]  payload_bytes,
    output logic        error_code,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tds_pkg::*;

    logic        in_valid_reg;
    tds_item_t   item_reg;
    tds_state_t  state_reg;
    tds_state_t  state_next;
    tds_result_t step_result;
    logic        out_valid_reg;
    tds_result_t result_reg;
    logic [3:0]  retry_limit_reg;
    logic        advance;
    logic        cfg_write;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_RETRY_LIMIT);
    assign prdata    = (paddr == REG_RETRY_LIMIT) ? {28'd0, retry_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            retry_limit_reg <= RETRY_RESET;
        else if (cfg_write)
            retry_limit_reg <= pwdata[3:0];
    end

    // request register moves on when the result register is free or drains
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= '{action, file_found, block_bytes, reply_opcode, reply_block,
                          reply_length};
    end

    // decision logic
    tds_step u_step
    (
        .item        (item_reg),
        .state       (state_reg),
        .retry_limit (retry_limit_reg),
        .state_next  (state_next),
        .result      (step_result)
    );

    // transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.current_block <= FIRST_BLOCK;
            state_reg.sends_done    <= 4'd0;
            state_reg.held_length   <= 10'd0;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg && step_result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && step_result.valid)
            result_reg <= step_result;
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = result_reg.kind;
    assign block_number  = result_reg.block_number;
    assign payload_bytes = result_reg.payload_bytes;
    assign error_code    = result_reg.error_code;

    // checks
    `TDS_ASSERT_ALWAYS(a_block_nonzero, state_reg.current_block != 16'd0)
    `TDS_ASSERT_ALWAYS(a_wait_has_send,
        (state_reg.phase != PH_WAIT) || (state_reg.sends_done != 4'd0))
    `TDS_ASSERT_ALWAYS(a_length_bound, state_reg.held_length <= BLOCK_SIZE)
    `TDS_ASSERT_NEXT(a_done_to_idle,
        in_valid_reg && advance && step_result.valid && (step_result.kind == KIND_DONE),
        state_reg.phase == PH_IDLE)

endmodule

@@ test/tb_tftp_data_sender_unit.sv @@
// self-checking testbench for the tftp data sender unit
`timescale 1ns / 1ps

module tb_tftp_data_sender_unit;
    import tds_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 4;

    // one row of the directed stimulus
    typedef struct {
        tds_item_t   req;
        bit          typed;
        tds_result_t res;
        bit          is_cfg;
        logic [3:0]  cfg_val;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = '0;
    logic        file_found = 1'b0;
    logic [9:0]  block_bytes = '0;
    logic [7:0]  reply_opcode = '0;
    logic [15:0] reply_block = '0;
    logic [9:0]  reply_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [15:0] block_number;
    logic [9:0]  payload_bytes;
    logic        error_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic        paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the transfer state and the retry register
    logic [1:0]  tx_phase;
    logic [15:0] tx_block;
    logic [3:0]  tx_sends;
    logic [9:0]  tx_held;
    logic [3:0]  tx_retry_limit;
    bit          wrap_seen;

    tds_result_t expected_results[$];
    dir_row_t    dir_tab[$];

    int  n_errors = 0;
    int  n_requests = 0;
    int  n_results_due = 0;
    int  n_checked = 0;
    int  n_cfg_writes = 0;
    int  cycles = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    tftp_data_sender_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .file_found    (file_found),
        .block_bytes   (block_bytes),
        .reply_opcode  (reply_opcode),
        .reply_block   (reply_block),
        .reply_length  (reply_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .block_number  (block_number),
        .payload_bytes (payload_bytes),
        .error_code    (error_code),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached, %0d results outstanding", $time,
                     expected_results.size());
            $display("FAIL tftp_data_sender_unit");
            $finish;
        end
    end

    // failed ack or timeout: resend the block or give up
    function automatic void resend_or_abort(output tds_result_t res);
        res = '0;
        res.valid = 1'b1;
        if (tx_sends >= tx_retry_limit)
        begin
            tx_phase = PH_IDLE;
            res.kind = KIND_ERROR;
            res.error_code = ERR_RETRIES;
        end
        else
        begin
            tx_sends = tx_sends + 4'd1;
            res.kind = KIND_DATA;
            res.block_number = tx_block;
            res.payload_bytes = tx_held;
        end
    endfunction

    // one step of the sender protocol; res.valid low when the request is ignored
    function automatic void sender_step(input tds_item_t req, output tds_result_t res);
        res = '0;
        case (req.action)
            ACT_START:
            begin
                if (tx_phase == PH_IDLE)
                begin
                    res.valid = 1'b1;
                    if (!req.file_found)
                    begin
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_NOT_FOUND;
                    end
                    else
                    begin
                        tx_block = FIRST_BLOCK;
                        tx_sends = '0;
                        tx_held = '0;
                        tx_phase = PH_LOAD;
                        res.kind = KIND_FETCH;
                        res.block_number = tx_block;
                    end
                end
            end
            ACT_LOADED:
            begin
                if (tx_phase == PH_LOAD)
                begin
                    // oversized blocks saturate to a full block
                    tx_held = (req.block_bytes > BLOCK_SIZE) ? BLOCK_SIZE : req.block_bytes;
                    tx_sends = 4'd1;
                    tx_phase = PH_WAIT;
                    res.valid = 1'b1;
                    res.kind = KIND_DATA;
                    res.block_number = tx_block;
                    res.payload_bytes = tx_held;
                end
            end
            ACT_REPLY:
            begin
                if (tx_phase == PH_WAIT)
                begin
                    if (req.reply_length >= MIN_REPLY_LEN && req.reply_opcode == OP_ACK &&
                        req.reply_block == tx_block)
                    begin
                        res.valid = 1'b1;
                        if (tx_held < BLOCK_SIZE)
                        begin
                            tx_phase = PH_IDLE;
                            res.kind = KIND_DONE;
                        end
                        else
                        begin
                            if (tx_block == LAST_BLOCK)
                            begin
                                tx_block = FIRST_BLOCK;
                                wrap_seen = 1'b1;
                            end
                            else
                                tx_block = tx_block + 16'd1;
                            tx_sends = '0;
                            tx_phase = PH_LOAD;
                            res.kind = KIND_FETCH;
                        end
                        res.block_number = tx_block;
                    end
                    else
                        resend_or_abort(res);
                end
            end
            default:
            begin
                if (tx_phase == PH_WAIT)
                    resend_or_abort(res);
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic tds_item_t rand_item();
        tds_item_t r;
        r.action = 2'($urandom_range(0, 3));
        r.file_found = 1'($urandom_range(0, 1));
        r.block_bytes = 10'($urandom_range(0, 1023));
        r.reply_opcode = 8'($urandom_range(0, 255));
        r.reply_block = 16'($urandom_range(0, 65535));
        r.reply_length = 10'($urandom_range(0, 1023));
        return r;
    endfunction

    function automatic dir_row_t row(input logic [1:0] a, input logic f, input logic [9:0] b,
                                     input logic [7:0] op, input logic [15:0] rb,
                                     input logic [9:0] rl, input bit typed, input logic v,
                                     input logic [1:0] kind, input logic [15:0] bn,
                                     input logic [9:0] pb, input logic ec);
        dir_row_t d;
        d.req = '{a, f, b, op, rb, rl};
        d.typed = typed;
        d.res = '{v, kind, bn, pb, ec};
        d.is_cfg = 1'b0;
        d.cfg_val = '0;
        return d;
    endfunction

    function automatic dir_row_t cfg_row(input logic [3:0] val);
        dir_row_t d;
        d = row(ACT_START, 1'b0, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        d.is_cfg = 1'b1;
        d.cfg_val = val;
        return d;
    endfunction

    // offer one request, predict at acceptance, then maybe leave a gap
    task automatic push_req(input tds_item_t req, input bit typed, input tds_result_t want);
        tds_result_t res;
        int gap;
        in_valid <= 1'b1;
        action <= req.action;
        file_found <= req.file_found;
        block_bytes <= req.block_bytes;
        reply_opcode <= req.reply_opcode;
        reply_block <= req.reply_block;
        reply_length <= req.reply_length;
        do
            @(posedge clk);
        while (in_stall);
        n_requests++;
        sender_step(req, res);
        if (typed)
            res = want;
        if (res.valid)
        begin
            expected_results.push_back(res);
            n_results_due++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for the block to drain, then optionally write the register and read it back
    task automatic retry_limit_access(input bit do_write, input logic [3:0] val);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (do_write)
        begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            penable <= 1'b0;
            paddr <= REG_RETRY_LIMIT;
            pwdata <= {28'd0, val};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            tx_retry_limit = val;
            n_cfg_writes++;
        end
        // read back
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= REG_RETRY_LIMIT;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[3:0] !== tx_retry_limit)
        begin
            n_errors++;
            $display("%0t: retry_limit readback expected %0d got %0d", $time,
                     tx_retry_limit, prdata[3:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // one transfer: mostly well-formed, with bad replies, timeouts and stray requests
    task automatic random_transfer();
        tds_item_t r;
        int k;
        r = rand_item();
        r.action = ACT_START;
        r.file_found = ($urandom_range(0, 7) != 0);
        push_req(r, 1'b0, '0);
        while (tx_phase != PH_IDLE)
        begin
            r = rand_item();
            k = $urandom_range(0, 99);
            if (k < 8)
                ;
            else if (tx_phase == PH_LOAD)
            begin
                r.action = ACT_LOADED;
                if ($urandom_range(0, 3) == 0)
                    r.block_bytes = 10'($urandom_range(0, 511));
                else if ($urandom_range(0, 4) == 0)
                    r.block_bytes = 10'($urandom_range(513, 1023));
                else
                    r.block_bytes = BLOCK_SIZE;
            end
            else
            begin
                r.action = ACT_REPLY;
                r.reply_opcode = OP_ACK;
                r.reply_block = tx_block;
                r.reply_length = 10'($urandom_range(4, 1023));
                if (k >= 70 && k < 80)
                    r.action = ACT_TIMEOUT;
                else if (k >= 80 && k < 86)
                    r.reply_length = 10'($urandom_range(0, 3));
                else if (k >= 86 && k < 92)
                begin
                    r.reply_opcode = 8'($urandom_range(0, 254));
                    if (r.reply_opcode >= OP_ACK)
                        r.reply_opcode = r.reply_opcode + 8'd1;
                end
                else if (k >= 92)
                    r.reply_block = tx_block ^ 16'($urandom_range(1, 65535));
            end
            push_req(r, 1'b0, '0);
        end
    endtask

    // result side: random stalls, quiet stretches and long holds on request
    always @(posedge clk)
    begin
        int r;
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (!stalls_on)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        tds_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result kind %0d block %0d", $time,
                         result_kind, block_number);
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (result_kind !== want.kind)
                begin
                    n_errors++;
                    $display("%0t: result_kind expected %0d got %0d", $time,
                             want.kind, result_kind);
                end
                if (block_number !== want.block_number)
                begin
                    n_errors++;
                    $display("%0t: block_number expected %0d got %0d", $time,
                             want.block_number, block_number);
                end
                if (payload_bytes !== want.payload_bytes)
                begin
                    n_errors++;
                    $display("%0t: payload_bytes expected %0d got %0d", $time,
                             want.payload_bytes, payload_bytes);
                end
                if (error_code !== want.error_code)
                begin
                    n_errors++;
                    $display("%0t: error_code expected %0d got %0d", $time,
                             want.error_code, error_code);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int base;
        int n_xfer;
        int cfg_idx;
        tx_phase = PH_IDLE;
        tx_block = FIRST_BLOCK;
        tx_sends = '0;
        tx_held = '0;
        tx_retry_limit = RETRY_RESET;
        wrap_seen = 1'b0;

        // directed rows: idle, busy, oversized block, each failed reply, abort, ack paths
        dir_tab.push_back(row(ACT_REPLY, 0, 0, OP_ACK, 1, 4, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_TIMEOUT, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_LOADED, 0, BLOCK_SIZE, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_START, 0, 0, 0, 0, 0, 1, 1, KIND_ERROR, 0, 0,
                              ERR_NOT_FOUND));
        dir_tab.push_back(row(ACT_START, 1, 0, 0, 0, 0, 1, 1, KIND_FETCH, FIRST_BLOCK, 0, 0));
        dir_tab.push_back(row(ACT_START, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_REPLY, 0, 0, OP_ACK, 1, 4, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_TIMEOUT, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_LOADED, 0, 10'h3FF, 0, 0, 0, 1, 1, KIND_DATA, 1,
                              BLOCK_SIZE, 0));
        dir_tab.push_back(row(ACT_LOADED, 0, 7, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_REPLY, 0, 0, OP_ACK, 1, 3, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_REPLY, 0, 0, 8'd3, 1, 4, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_REPLY, 0, 0, OP_ACK, 2, 4, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_TIMEOUT, 0, 0, 0, 0, 0, 1, 1, KIND_ERROR, 0, 0,
                              ERR_RETRIES));
        dir_tab.push_back(row(ACT_START, 1, 0, 0, 0, 0, 1, 1, KIND_FETCH, FIRST_BLOCK, 0, 0));
        dir_tab.push_back(row(ACT_LOADED, 0, BLOCK_SIZE, 0, 0, 0, 1, 1, KIND_DATA, 1,
                              BLOCK_SIZE, 0));
        dir_tab.push_back(row(ACT_REPLY, 0, 0, OP_ACK, 1, 4, 1, 1, KIND_FETCH, 2, 0, 0));
        dir_tab.push_back(row(ACT_LOADED, 0, 0, 0, 0, 0, 1, 1, KIND_DATA, 2, 0, 0));
        dir_tab.push_back(row(ACT_REPLY, 0, 0, OP_ACK, 2, 516, 1, 1, KIND_DONE, 2, 0, 0));
        dir_tab.push_back(cfg_row(4'd0));
        dir_tab.push_back(row(ACT_START, 1, 10'h3FF, 8'hFF, 16'hFFFF, 10'h3FF,
                              0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_LOADED, 0, 511, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(ACT_TIMEOUT, 0, 0, 0, 0, 0, 1, 1, KIND_ERROR, 0, 0,
                              ERR_RETRIES));
        dir_tab.push_back(cfg_row(4'd15));

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the retry register
        retry_limit_access(1'b0, '0);

        // directed part
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                retry_limit_access(1'b1, dir_tab[i].cfg_val);
            else
                push_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
        end

        // random transfers, with register changes and pressure phases
        base = n_results_due;
        n_xfer = 0;
        cfg_idx = 0;
        while (n_results_due - base < RANDOM_ITEMS)
        begin
            if (n_xfer % 25 == 24)
            begin
                case (cfg_idx % 5)
                    0: retry_limit_access(1'b1, 4'd1);
                    1: retry_limit_access(1'b1, 4'd15);
                    2: retry_limit_access(1'b1, 4'd0);
                    3: retry_limit_access(1'b1, 4'd2);
                    default: retry_limit_access(1'b1, 4'($urandom_range(1, 15)));
                endcase
                cfg_idx++;
            end
            // long receiver hold while requests keep coming
            if (n_xfer == 10 || n_xfer == 70)
            begin
                hold_req <= hold_req + 1;
                gaps_on = 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                gaps_on = 1'b0;
                stalls_on <= 1'b0;
            end
            else
            begin
                gaps_on = 1'b1;
                stalls_on <= 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                push_req(rand_item(), 1'b0, '0);
            random_transfer();
            n_xfer++;
        end
        in_valid <= 1'b0;
        stalls_on <= 1'b1;

        // wait for the last results
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d requests and %0d checked results over %0d random transfers",
                 n_requests, n_checked, n_xfer);
        $display("retry limit written %0d times, block number wrap reached: %0d",
                 n_cfg_writes, wrap_seen);
        if (n_errors == 0)
            $display("PASS tftp_data_sender_unit");
        else
            $display("FAIL tftp_data_sender_unit");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tds_pkg.sv
hw/rtl/tds_step.sv
hw/rtl/tftp_data_sender_unit.sv
test/tb_tftp_data_sender_unit.sv
